@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the comment stripper.
// Each macro takes a label, clock, active-low reset, property terms and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/ccs_pkg.sv @@
// Types and constants of the C comment stripper.
// No dependencies; used by the channel interfaces and the core.
`timescale 1ns / 1ps

package ccs_pkg;

  // Request operation codes.
  localparam logic [1:0] OpByte    = 2'd0;
  localparam logic [1:0] OpIdent   = 2'd1;
  localparam logic [1:0] OpNewFile = 2'd2;

  // Character codes the lexer reacts to.
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChReturn    = 8'h0D;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChStar      = 8'h2A;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChQuote     = 8'h27;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChFormFeed  = 8'h0C;

  // Result queue geometry.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = 2;

  // Input request payload.
  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_in;
    logic       tab_pick;
  } ccs_in_t;

  // Output result payload.
  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
  } ccs_out_t;

endpackage

@@ rtl/core/ccs_in_if.sv @@
// Valid/ready channel that carries source requests into the stripper.
// Depends on ccs_pkg for the payload type.
`timescale 1ns / 1ps

interface ccs_in_if;
  logic              valid;
  logic              ready;
  ccs_pkg::ccs_in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/ccs_out_if.sv @@
// Valid/ready channel that carries stripped output bytes.
// Depends on ccs_pkg for the payload type.
`timescale 1ns / 1ps

interface ccs_out_if;
  logic              valid;
  logic              ready;
  ccs_pkg::ccs_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/c_comment_stripper_core.sv @@
// C comment stripper core: lexer state machine and result queue.
// Depends on ccs_pkg, ccs_in_if, ccs_out_if and assert_macros.svh.
`timescale 1ns / 1ps

// The block takes one request per cycle while the queue has room. Each
// accepted request waits in an input register until the queue has room,
// then passes through the lexer into a four-entry result queue; the first
// byte it causes can leave in the cycle after it is written. A request can
// yield two bytes (a held slash released by an ordinary byte), so the input
// register moves on only while the queue has two free entries, and a long
// run of such requests is held back by the output. Requests that yield
// nothing (comment bodies, carriage returns, repeated blanks) add no entry.
// A new-file request clears the lexer state; reset needs no clearing pass.

`include "assert_macros.svh"

module c_comment_stripper_core (
  input  logic clk_i,
  input  logic rst_ni,
  ccs_in_if.sink    req_i,
  ccs_out_if.source rsp_o
);

  typedef enum logic [3:0] {
    LEX_NORMAL     = 4'd0,
    LEX_CHAR       = 4'd1,
    LEX_STRING     = 4'd2,
    LEX_CHAR_ESC   = 4'd3,
    LEX_STR_ESC    = 4'd4,
    LEX_SLASH      = 4'd5,
    LEX_LINE_CMT   = 4'd6,
    LEX_BLOCK_CMT  = 4'd7,
    LEX_BLOCK_STAR = 4'd8
  } lex_e;

  localparam int unsigned FifoCw = ccs_pkg::FifoAw + 1;
  localparam logic [FifoCw-1:0] AdvanceLimit = FifoCw'(ccs_pkg::FifoDepth - 2);

  // Input register.
  logic              stage_v_q;
  ccs_pkg::ccs_in_t  stage_q;

  // Lexer state.
  lex_e lex_q, lex_d;
  logic sep_q, sep_d;

  // Result queue.
  ccs_pkg::ccs_out_t           fifo_q [ccs_pkg::FifoDepth];
  logic [ccs_pkg::FifoAw-1:0]  wr_q, rd_q, wr_nxt;
  logic [FifoCw-1:0]           cnt_q;

  logic       advance, pop;
  logic [1:0] n_res;
  logic [7:0] ch0, ch1, sep_ch, c;

  // The staged request moves on when the queue can take two results.
  assign advance   = stage_v_q && (cnt_q <= AdvanceLimit);
  assign req_i.ready = !stage_v_q || advance;
  assign pop       = rsp_o.valid && rsp_o.ready;
  assign wr_nxt    = wr_q + 1'b1;

  assign rsp_o.valid = (cnt_q != '0);
  assign rsp_o.data  = fifo_q[rd_q];

  assign c      = stage_q.char_in;
  assign sep_ch = stage_q.tab_pick ? ccs_pkg::ChTab : ccs_pkg::ChSpace;

  // Lexer: next state and up to two output bytes for the staged request.
  always_comb begin
    lex_d = lex_q;
    sep_d = sep_q;
    n_res = 2'd0;
    ch0   = c;
    ch1   = c;
    case (stage_q.operation)
      ccs_pkg::OpNewFile: begin
        lex_d = LEX_NORMAL;
        sep_d = 1'b0;
      end
      ccs_pkg::OpIdent: begin
        if (lex_q == LEX_SLASH) begin
          ch0   = ccs_pkg::ChSlash;
          n_res = 2'd1;
          lex_d = LEX_NORMAL;
        end
        sep_d = 1'b0;
      end
      ccs_pkg::OpByte: begin
        case (lex_q)
          LEX_CHAR: begin
            if (c == ccs_pkg::ChQuote) begin
              lex_d = LEX_NORMAL;
            end else if (c == ccs_pkg::ChBackslash) begin
              lex_d = LEX_CHAR_ESC;
            end
            n_res = 2'd1;
          end
          LEX_STRING: begin
            if (c == ccs_pkg::ChDquote) begin
              lex_d = LEX_NORMAL;
            end else if (c == ccs_pkg::ChBackslash) begin
              lex_d = LEX_STR_ESC;
            end
            n_res = 2'd1;
          end
          LEX_CHAR_ESC: begin
            lex_d = LEX_CHAR;
            n_res = 2'd1;
          end
          LEX_STR_ESC: begin
            lex_d = LEX_STRING;
            n_res = 2'd1;
          end
          LEX_SLASH: begin
            if (c == ccs_pkg::ChSlash || c == ccs_pkg::ChStar) begin
              lex_d = (c == ccs_pkg::ChSlash) ? LEX_LINE_CMT : LEX_BLOCK_CMT;
              if (!sep_q) begin
                sep_d = 1'b1;
                ch0   = sep_ch;
                n_res = 2'd1;
              end
            end else begin
              // Held slash released, followed by the byte as it is.
              ch0   = ccs_pkg::ChSlash;
              ch1   = c;
              n_res = 2'd2;
              lex_d = LEX_NORMAL;
            end
          end
          LEX_LINE_CMT: begin
            if (c == ccs_pkg::ChNewline) begin
              lex_d = LEX_NORMAL;
              n_res = 2'd1;
            end
          end
          LEX_BLOCK_CMT: begin
            if (c == ccs_pkg::ChStar) begin
              lex_d = LEX_BLOCK_STAR;
            end
          end
          LEX_BLOCK_STAR: begin
            if (c == ccs_pkg::ChSlash) begin
              lex_d = LEX_NORMAL;
            end else if (c != ccs_pkg::ChStar) begin
              lex_d = LEX_BLOCK_CMT;
            end
          end
          default: begin
            // Normal code, and any unused state code.
            lex_d = LEX_NORMAL;
            if (c == ccs_pkg::ChNewline) begin
              n_res = 2'd1;
              sep_d = 1'b1;
            end else if (c == ccs_pkg::ChReturn) begin
              n_res = 2'd0;
            end else if (c == ccs_pkg::ChSpace || c == ccs_pkg::ChTab ||
                         c == ccs_pkg::ChFormFeed) begin
              if (!sep_q) begin
                sep_d = 1'b1;
                ch0   = sep_ch;
                n_res = 2'd1;
              end
            end else if (c == ccs_pkg::ChSlash) begin
              lex_d = LEX_SLASH;
              sep_d = 1'b0;
            end else begin
              if (c == ccs_pkg::ChQuote) begin
                lex_d = LEX_CHAR;
              end else if (c == ccs_pkg::ChDquote) begin
                lex_d = LEX_STRING;
              end
              n_res = 2'd1;
              sep_d = 1'b0;
            end
          end
        endcase
      end
      default: begin
        // Unused operation code: no effect.
      end
    endcase
  end

  // Input register, lexer state and queue pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
      lex_q     <= LEX_NORMAL;
      sep_q     <= 1'b0;
      wr_q      <= '0;
      rd_q      <= '0;
      cnt_q     <= '0;
    end else begin
      if (req_i.ready) begin
        stage_v_q <= req_i.valid;
      end
      if (advance) begin
        lex_q <= lex_d;
        sep_q <= sep_d;
        wr_q  <= wr_q + ccs_pkg::FifoAw'(n_res);
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (advance ? FifoCw'(n_res) : '0) - FifoCw'(pop);
    end
  end

  // Payload registers: staged request and queue entries.
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      stage_q <= req_i.data;
    end
    if (advance && n_res != 2'd0) begin
      fifo_q[wr_q].out_char    <= ch0;
      fifo_q[wr_q].last_of_run <= (n_res == 2'd1);
    end
    if (advance && n_res == 2'd2) begin
      fifo_q[wr_nxt].out_char    <= ch1;
      fifo_q[wr_nxt].last_of_run <= 1'b1;
    end
  end

  // Checks on the queue and the lexer.
  `ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, cnt_q <= FifoCw'(ccs_pkg::FifoDepth), "result queue overflow")
  `ASSERT_ALWAYS(a_run_closed, clk_i, rst_ni, cnt_q == '0 || fifo_q[wr_q - 1'b1].last_of_run, "queued run not closed")
  `ASSERT_NEXT(a_stage_hold, clk_i, rst_ni, stage_v_q && !advance, stage_v_q && $stable(stage_q), "staged request lost")
  `ASSERT_NEXT(a_new_file, clk_i, rst_ni, advance && stage_q.operation == ccs_pkg::OpNewFile, lex_q == LEX_NORMAL && !sep_q, "new file did not clear the lexer")

endmodule
